[design/assert_macros.svh]
// Assertion helpers for the RTL files (included by otrt_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset.
`define OTRT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("otrt assertion failed");
// Condition must never be true outside reset.
`define OTRT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("otrt forbidden condition seen");
`else
`define OTRT_ASSERT(label, clk, rst, prop)
`define OTRT_NEVER(label, clk, rst, cond)
`endif
`endif

[design/otrt_pkg.sv]
`default_nettype none
package otrt_pkg;

   // Field widths
   localparam int TAG_W    = 6;
   localparam int KIND_W   = 3;
   localparam int CMD_W    = 2;
   localparam int TMO_W    = 16;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd60;

   // Input commands
   localparam logic [CMD_W-1:0] CMD_ISSUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ISSUED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ROUTED  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NOTICE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd5;

   // Queued item, classified by the front end
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [15:0]      client_id;
      logic [15:0]      server_id;
      logic [31:0]      orig_seq;
      logic [15:0]      req_cmd;
      logic [31:0]      req_id;
      logic [TAG_W-1:0] slot_tag;
      logic             tag_ok;
   } item_type;

   // One slot of the table memory
   typedef struct packed {
      logic [31:0] stamp;
      logic [15:0] client;
      logic [15:0] server;
      logic [31:0] seq;
      logic [15:0] cmd;
      logic [31:0] reqid;
   } slot_type;

   // One result
   typedef struct packed {
      logic [KIND_W-1:0] out_kind;
      logic [15:0]       dest_client;
      logic [15:0]       dest_server;
      logic [TAG_W-1:0]  out_tag;
      logic [31:0]       out_seq;
      logic [15:0]       out_cmd;
      logic [31:0]       out_id;
      logic              last;
   } rsp_type;

endpackage
`default_nettype wire

[design/otrt_front.sv]
`default_nettype none
module otrt_front import otrt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [CMD_W-1:0] req_command,
   input  wire logic [15:0]      req_client_id,
   input  wire logic [15:0]      req_server_id,
   input  wire logic [31:0]      req_orig_seq,
   input  wire logic [15:0]      req_req_cmd,
   input  wire logic [31:0]      req_req_id,
   input  wire logic [TAG_W-1:0] req_slot_tag,
   output logic                  q_valid,
   input  wire logic             q_pop,
   output item_type              q_item
);

   localparam logic [TAG_W:0] DEPTH_V = (TAG_W+1)'(TABLE_DEPTH);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push;

   // Classify the incoming item
   always_comb begin
      new_item.command   = req_command;
      new_item.client_id = req_client_id;
      new_item.server_id = req_server_id;
      new_item.orig_seq  = req_orig_seq;
      new_item.req_cmd   = req_req_cmd;
      new_item.req_id    = req_req_id;
      new_item.slot_tag  = req_slot_tag;
      new_item.tag_ok    = {1'b0, req_slot_tag} < DEPTH_V;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

[design/otrt_back.sv]
`default_nettype none
`include "assert_macros.svh"
module otrt_back import otrt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [TMO_W-1:0] csr_wr_data,
   input  wire logic             q_valid,
   output logic                  q_pop,
   input  wire item_type         q_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp
);

   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DROP = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      cnt_ff, cnt_in;
   logic [SLOT_W-1:0]      ptr_ff, ptr_in;
   logic [31:0]            now_ff, now_in;
   logic [TMO_W-1:0]       tmo_ff;
   item_type               cur_ff, cur_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   pend_valid_ff, pend_valid_in;
   rsp_type                pend_ff, pend_in;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;
   slot_type               mem [TABLE_DEPTH];
   slot_type               rd_ff;
   slot_type               wr_data;
   logic                   mem_we;
   logic                   emit;
   rsp_type                emit_data;
   logic                   out_free;
   logic                   stale;
   logic                   qualifies;
   logic                   srv_hit;
   logic [SLOT_W-1:0]      slot_next;
   logic [SLOT_W-1:0]      tag_idx;
   rsp_type                found;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign stale     = (rd_ff.stamp + {16'd0, tmo_ff}) < now_ff;
   assign qualifies = !valid_ff[slot_ff] || stale;
   assign srv_hit   = valid_ff[slot_ff] && (rd_ff.server == cur_ff.server_id);
   assign slot_next = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign tag_idx   = q_item.slot_tag[SLOT_W-1:0];

   // Stored slot viewed as a result
   always_comb begin
      found.out_kind    = KIND_NOTICE;
      found.dest_client = rd_ff.client;
      found.dest_server = rd_ff.server;
      found.out_tag     = TAG_W'(slot_ff);
      found.out_seq     = rd_ff.seq;
      found.out_cmd     = rd_ff.cmd;
      found.out_id      = rd_ff.reqid;
      found.last        = 1'b0;
   end

   always_comb begin
      wr_data.stamp  = now_ff;
      wr_data.client = cur_ff.client_id;
      wr_data.server = cur_ff.server_id;
      wr_data.seq    = cur_ff.orig_seq;
      wr_data.cmd    = cur_ff.req_cmd;
      wr_data.reqid  = cur_ff.req_id;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      now_in        = now_ff;
      cur_in        = cur_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      mem_we        = 1'b0;
      emit          = 1'b0;
      emit_data     = '0;
      q_pop         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               cur_in        = q_item;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               case (q_item.command)
                  CMD_ISSUE: begin
                     slot_in  = ptr_ff;
                     state_in = S_RD;
                  end
                  CMD_RESP: begin
                     if (q_item.tag_ok && valid_ff[tag_idx]) begin
                        slot_in  = tag_idx;
                        state_in = S_RD;
                     end else begin
                        state_in = S_DROP;
                     end
                  end
                  CMD_CLEAR: begin
                     slot_in  = '0;
                     state_in = S_RD;
                  end
                  default: begin
                     now_in = now_ff + 32'd1;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            case (cur_ff.command)
               CMD_ISSUE: begin
                  emit_data.dest_client = cur_ff.client_id;
                  emit_data.dest_server = cur_ff.server_id;
                  emit_data.out_seq     = cur_ff.orig_seq;
                  emit_data.out_cmd     = cur_ff.req_cmd;
                  emit_data.out_id      = cur_ff.req_id;
                  emit_data.last        = 1'b1;
                  if (qualifies) begin
                     emit_data.out_kind = KIND_ISSUED;
                     emit_data.out_tag  = TAG_W'(slot_ff);
                     if (out_free) begin
                        emit              = 1'b1;
                        mem_we            = 1'b1;
                        valid_in[slot_ff] = 1'b1;
                        ptr_in            = slot_next;
                        state_in          = S_IDLE;
                     end
                  end else if (cnt_ff == LAST_SLOT) begin
                     emit_data.out_kind = KIND_FULL;
                     if (out_free) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else begin
                     cnt_in   = cnt_ff + 1'b1;
                     slot_in  = slot_next;
                     state_in = S_RD;
                  end
               end
               CMD_RESP: begin
                  emit_data          = found;
                  emit_data.out_kind = KIND_ROUTED;
                  emit_data.last     = 1'b1;
                  if (out_free) begin
                     emit              = 1'b1;
                     valid_in[slot_ff] = 1'b0;
                     state_in          = S_IDLE;
                  end
               end
               default: begin
                  // Clear: hold one notice back so the final one carries last
                  emit_data = pend_ff;
                  if (srv_hit && pend_valid_ff && !out_free) begin
                     state_in = S_CHK;
                  end else begin
                     if (srv_hit) begin
                        emit                    = pend_valid_ff;
                        pend_valid_in           = 1'b1;
                        pend_in                 = found;
                        pend_in.dest_server     = cur_ff.server_id;
                        valid_in[slot_ff]       = 1'b0;
                     end
                     slot_in  = slot_next;
                     state_in = (slot_ff == LAST_SLOT) ? S_FIN : S_RD;
                  end
               end
            endcase
         end
         S_FIN: begin
            if (pend_valid_ff) begin
               emit_data      = pend_ff;
               emit_data.last = 1'b1;
            end else begin
               emit_data.out_kind    = KIND_NONE;
               emit_data.dest_server = cur_ff.server_id;
               emit_data.last        = 1'b1;
            end
            if (out_free) begin
               emit          = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_DROP: begin
            emit_data.out_kind = KIND_DROPPED;
            emit_data.out_tag  = cur_ff.slot_tag;
            emit_data.last     = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ptr_ff        <= '0;
         now_ff        <= '0;
         tmo_ff        <= TIMEOUT_RESET;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         now_ff        <= now_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_wr_en) begin
            tmo_ff <= csr_wr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      cnt_ff  <= cnt_in;
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   // Slot table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot_ff] <= wr_data;
      end
      rd_ff <= mem[slot_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `OTRT_NEVER(a_ptr_range, clock, reset, ptr_ff > LAST_SLOT)
   `OTRT_ASSERT(a_idle_no_pend, clock, reset, (state_ff == S_IDLE) |-> !pend_valid_ff)
   `OTRT_ASSERT(a_chk_after_rd, clock, reset,
      (state_ff == S_CHK) |-> ($past(state_ff) == S_RD || $past(state_ff) == S_CHK))

endmodule
`default_nettype wire

[design/outstanding_request_tag_table.sv]
// Outstanding request tag table. Each input transfer is queued by a two-entry front queue and
// handled by a back-end sequencer over a single-port slot memory; each slot visited passes a
// read state, then a check state. An issue visits slots until one is free or stale (up to
// TABLE_DEPTH); a clear always visits every slot; a response is dropped without a slot read
// when its tag names no valid slot, else it reads that slot and is routed; a tick only
// advances the time counter. Any result waits while a stalled result port still holds the
// one before it. Results leave through one output register. The table is empty after reset,
// with no clearing pass.
`default_nettype none
module outstanding_request_tag_table import otrt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [TMO_W-1:0]  csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CMD_W-1:0]  req_command,
   input  wire logic [15:0]       req_client_id,
   input  wire logic [15:0]       req_server_id,
   input  wire logic [31:0]       req_orig_seq,
   input  wire logic [15:0]       req_req_cmd,
   input  wire logic [31:0]       req_req_id,
   input  wire logic [TAG_W-1:0]  req_slot_tag,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [KIND_W-1:0]      rsp_out_kind,
   output logic [15:0]            rsp_dest_client,
   output logic [15:0]            rsp_dest_server,
   output logic [TAG_W-1:0]       rsp_out_tag,
   output logic [31:0]            rsp_out_seq,
   output logic [15:0]            rsp_out_cmd,
   output logic [31:0]            rsp_out_id,
   output logic                   rsp_last
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;
   rsp_type  rsp;

   otrt_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_client_id (req_client_id),
      .req_server_id (req_server_id),
      .req_orig_seq  (req_orig_seq),
      .req_req_cmd   (req_req_cmd),
      .req_req_id    (req_req_id),
      .req_slot_tag  (req_slot_tag),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_item        (q_item)
   );

   otrt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   // Result fields
   assign rsp_out_kind    = rsp.out_kind;
   assign rsp_dest_client = rsp.dest_client;
   assign rsp_dest_server = rsp.dest_server;
   assign rsp_out_tag     = rsp.out_tag;
   assign rsp_out_seq     = rsp.out_seq;
   assign rsp_out_cmd     = rsp.out_cmd;
   assign rsp_out_id      = rsp.out_id;
   assign rsp_last        = rsp.last;

endmodule
`default_nettype wire
